/* sv/tlv_field_stream_parser_assert.svh */
// Assertion helpers for the TLV field stream parser.
`ifndef TLV_FIELD_STREAM_PARSER_ASSERT_SVH
`define TLV_FIELD_STREAM_PARSER_ASSERT_SVH

// cons must hold in the same cycle as ante
`define TFSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define TFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tlvfsp_pkg.sv */
package tlvfsp_pkg;

  localparam int unsigned PFX_BYTES = 4;
  localparam int unsigned HDR_BYTES = 5;
  localparam int unsigned QDEPTH    = 3;
  localparam int unsigned QIDX_W    = 2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TRUNC   = 2'd2,
    KIND_SHORT   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  field_type;
    logic [31:0] field_length;
    logic [7:0]  payload_byte;
    logic        first_of_field;
    logic        last_of_field;
    logic        last_of_run;
  } result_t;

endpackage

/* sv/tlv_field_stream_parser.sv */
// A result word enters the result queue on the edge that accepts the byte that causes it.
// Throughput: one byte per cycle while s_tready holds and each byte gives at most one result;
// a byte that gives two results (field word plus discard) pushes both into the queue at once.
// A three-entry result queue decouples the sides; s_tready drops while it holds two or more.
// Reset (rst, synchronous): parser counters, prefix_mode and the queue clear at once.
module tlv_field_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,   // prefix_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // packet_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // [7:0] field_type, [39:8] field_length, [47:40] payload_byte
  output logic [3:0]  m_tuser,    // [1:0] kind, [2] first_of_field, [3] last_of_field
  output logic        m_tlast     // last_of_run
);

  localparam logic [2:0] PFX_N = 3'(tlvfsp_pkg::PFX_BYTES);
  localparam logic [2:0] HDR_N = 3'(tlvfsp_pkg::HDR_BYTES);

  logic        prefix_mode;
  logic [2:0]  pfx_cnt;
  logic [31:0] body_len;
  logic [31:0] body_used;
  logic [2:0]  hdr_cnt;
  logic [7:0]  cur_type;
  logic [31:0] cur_len;
  logic [31:0] pay_rem;

  logic [2:0]  pfx_cnt_next;
  logic [31:0] body_len_next;
  logic [31:0] body_used_next;
  logic [2:0]  hdr_cnt_next;
  logic [7:0]  cur_type_next;
  logic [31:0] cur_len_next;
  logic [31:0] pay_rem_next;

  tlvfsp_pkg::result_t q [tlvfsp_pkg::QDEPTH];
  tlvfsp_pkg::result_t q_next [tlvfsp_pkg::QDEPTH];
  logic [1:0] q_cnt;
  logic [1:0] q_cnt_next;

  logic    accept, pop, feed, last_pkt, short_frame;
  logic    v0, v1;
  tlvfsp_pkg::result_t r0, r1, push_a, push_b;
  logic [1:0] npush;
  logic [1:0] base;
  logic [31:0] len_shift, pay_dec;

  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (q_cnt <= 2'd1);
  assign last_pkt = s_tlast;

  // parser step for one byte
  always_comb begin
    pfx_cnt_next   = pfx_cnt;
    body_len_next  = body_len;
    body_used_next = body_used;
    hdr_cnt_next   = hdr_cnt;
    cur_type_next  = cur_type;
    cur_len_next   = cur_len;
    pay_rem_next   = pay_rem;
    feed           = 1'b1;
    v0             = 1'b0;
    v1             = 1'b0;
    r0             = '0;
    r1             = '0;
    len_shift      = {cur_len[23:0], s_tdata};
    pay_dec        = (pay_rem != 32'd0) ? pay_rem - 32'd1 : pay_rem;
    short_frame    = 1'b0;

    if (prefix_mode) begin
      if (pfx_cnt < PFX_N) begin
        body_len_next = {body_len[23:0], s_tdata};
        pfx_cnt_next  = pfx_cnt + 3'd1;
        feed          = 1'b0;
      end else if (body_used >= body_len) begin
        feed = 1'b0;
      end else begin
        body_used_next = body_used + 32'd1;
      end
    end

    if (feed) begin
      if (hdr_cnt == 3'd0) begin
        cur_type_next = s_tdata;
        hdr_cnt_next  = 3'd1;
      end else if (hdr_cnt < HDR_N) begin
        cur_len_next = len_shift;
        hdr_cnt_next = hdr_cnt + 3'd1;
        if (hdr_cnt == HDR_N - 3'd1) begin
          if (len_shift == 32'd0) begin
            v0                = 1'b1;
            r0.kind           = tlvfsp_pkg::KIND_EMPTY;
            r0.field_type     = cur_type;
            r0.first_of_field = 1'b1;
            r0.last_of_field  = 1'b1;
            hdr_cnt_next      = 3'd0;
          end else begin
            pay_rem_next = len_shift;
          end
        end
      end else begin
        v0                = 1'b1;
        r0.kind           = tlvfsp_pkg::KIND_PAYLOAD;
        r0.field_type     = cur_type;
        r0.field_length   = cur_len;
        r0.payload_byte   = s_tdata;
        r0.first_of_field = (pay_rem == cur_len);
        r0.last_of_field  = (pay_rem <= 32'd1);
        pay_rem_next      = pay_dec;
        if (pay_dec == 32'd0) begin
          hdr_cnt_next = 3'd0;
        end
      end
    end

    if (last_pkt) begin
      short_frame = prefix_mode &&
                    ((pfx_cnt_next < PFX_N) || (body_used_next < body_len_next));
      if (short_frame) begin
        v1      = 1'b1;
        r1.kind = tlvfsp_pkg::KIND_SHORT;
      end else if ((hdr_cnt_next >= HDR_N) && (pay_rem_next != 32'd0)) begin
        v1              = 1'b1;
        r1.kind         = tlvfsp_pkg::KIND_TRUNC;
        r1.field_type   = cur_type_next;
        r1.field_length = cur_len_next;
      end
      pfx_cnt_next   = 3'd0;
      body_len_next  = 32'd0;
      body_used_next = 32'd0;
      hdr_cnt_next   = 3'd0;
      pay_rem_next   = 32'd0;
    end

    r0.last_of_run = !v1;
    r1.last_of_run = 1'b1;
  end

  // queue the results of this byte, field word before discard
  always_comb begin
    push_a     = v0 ? r0 : r1;
    push_b     = r1;
    npush      = {1'b0, v0} + {1'b0, v1};
    base       = q_cnt - {1'b0, pop};
    q_cnt_next = base + (accept ? npush : 2'd0);
    for (int i = 0; i < int'(tlvfsp_pkg::QDEPTH); i++) begin
      if (pop && (i < int'(tlvfsp_pkg::QDEPTH) - 1)) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (accept && (npush != 2'd0) && (tlvfsp_pkg::QIDX_W'(i) == base)) begin
        q_next[i] = push_a;
      end
      if (accept && (npush == 2'd2) && (tlvfsp_pkg::QIDX_W'(i) == base + 2'd1)) begin
        q_next[i] = push_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode <= 1'b0;
      pfx_cnt     <= '0;
      body_len    <= '0;
      body_used   <= '0;
      hdr_cnt     <= '0;
      cur_type    <= '0;
      cur_len     <= '0;
      pay_rem     <= '0;
      q_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        prefix_mode <= cfg_data;
      end
      if (accept) begin
        pfx_cnt   <= pfx_cnt_next;
        body_len  <= body_len_next;
        body_used <= body_used_next;
        hdr_cnt   <= hdr_cnt_next;
        cur_type  <= cur_type_next;
        cur_len   <= cur_len_next;
        pay_rem   <= pay_rem_next;
      end
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(tlvfsp_pkg::QDEPTH); i++) begin
      q[i] <= q_next[i];
    end
  end

  assign m_tvalid = (q_cnt != 2'd0);
  assign m_tdata  = {q[0].payload_byte, q[0].field_length, q[0].field_type};
  assign m_tuser  = {q[0].last_of_field, q[0].first_of_field, q[0].kind};
  assign m_tlast  = q[0].last_of_run;

`include "tlv_field_stream_parser_assert.svh"

  `TFSP_ASSERT_NOW(a_cnt_range, 1'b1,
    (hdr_cnt <= HDR_N) && (pfx_cnt <= PFX_N), "counter out of range")
  `TFSP_ASSERT_NOW(a_body_bound, 1'b1, body_used <= body_len, "body count past body length")
  `TFSP_ASSERT_NEXT(a_pkt_clear, accept && s_tlast,
    (hdr_cnt == 3'd0) && (pfx_cnt == 3'd0) && (pay_rem == 32'd0),
    "state not cleared at packet end")
  `TFSP_ASSERT_NEXT(a_no_loss, accept && (npush == 2'd2) && !pop,
    q_cnt == $past(q_cnt) + 2'd2, "result dropped")

endmodule

/* dv/tlv_stream_checker.sv */
module tlv_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,    // [7:0] field_type, [39:8] field_length, [47:40] payload_byte
  input  logic [3:0]  m_tuser,    // [1:0] kind, [2] first_of_field, [3] last_of_field
  input  logic        m_tlast,
  output int          fails,
  output int          outstanding,
  output int          words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser shadow state
  logic        mode_pfx;
  logic [2:0]  pfx_seen;
  logic [31:0] body_len;
  logic [31:0] body_used;
  logic [2:0]  hdr_seen;
  logic [7:0]  fld_type;
  logic [31:0] fld_len;
  logic [31:0] fld_left;

  tlvfsp_pkg::result_t expected_words[$];

  initial begin
    fails       = 0;
    outstanding = 0;
    words_seen  = 0;
  end

  function automatic tlvfsp_pkg::result_t make_word(tlvfsp_pkg::kind_t k, logic [7:0] t,
                                                    logic [31:0] l, logic [7:0] p,
                                                    logic f, logic e);
    tlvfsp_pkg::result_t w;
    w.kind           = k;
    w.field_type     = t;
    w.field_length   = l;
    w.payload_byte   = p;
    w.first_of_field = f;
    w.last_of_field  = e;
    w.last_of_run    = 1'b0;
    return w;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    tlvfsp_pkg::result_t run_q[$];
    logic    feed;
    feed = 1'b1;
    if (mode_pfx) begin
      if (pfx_seen < tlvfsp_pkg::PFX_BYTES) begin
        body_len = {body_len[23:0], b};
        pfx_seen = pfx_seen + 3'd1;
        feed = 1'b0;
      end else if (body_used >= body_len) begin
        feed = 1'b0;  // past the body, dropped
      end else begin
        body_used = body_used + 32'd1;
      end
    end
    if (feed) begin
      if (hdr_seen == 3'd0) begin
        fld_type = b;
        hdr_seen = 3'd1;
      end else if (hdr_seen < tlvfsp_pkg::HDR_BYTES) begin
        fld_len  = {fld_len[23:0], b};
        hdr_seen = hdr_seen + 3'd1;
        if (hdr_seen == tlvfsp_pkg::HDR_BYTES) begin
          if (fld_len == 32'd0) begin
            run_q = {run_q, make_word(tlvfsp_pkg::KIND_EMPTY, fld_type, 32'd0, 8'd0,
                                      1'b1, 1'b1)};
            hdr_seen = 3'd0;
          end else begin
            fld_left = fld_len;
          end
        end
      end else begin
        run_q = {run_q, make_word(tlvfsp_pkg::KIND_PAYLOAD, fld_type, fld_len, b,
                                  fld_left == fld_len, fld_left <= 32'd1)};
        if (fld_left > 32'd0) fld_left = fld_left - 32'd1;
        if (fld_left == 32'd0) hdr_seen = 3'd0;
      end
    end
    if (lst) begin
      // short frame wins over a truncated field
      if (mode_pfx && (pfx_seen < tlvfsp_pkg::PFX_BYTES || body_used < body_len)) begin
        run_q = {run_q, make_word(tlvfsp_pkg::KIND_SHORT, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0)};
      end else if (hdr_seen >= tlvfsp_pkg::HDR_BYTES && fld_left > 32'd0) begin
        run_q = {run_q, make_word(tlvfsp_pkg::KIND_TRUNC, fld_type, fld_len, 8'd0,
                                  1'b0, 1'b0)};
      end
      pfx_seen  = 3'd0;
      body_len  = 32'd0;
      body_used = 32'd0;
      hdr_seen  = 3'd0;
      fld_left  = 32'd0;
    end
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].last_of_run = 1'b1;
    end
    expected_words = {expected_words, run_q};
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    tlvfsp_pkg::result_t want;
    if (rst) begin
      mode_pfx  = 1'b0;
      pfx_seen  = 3'd0;
      body_len  = 32'd0;
      body_used = 32'd0;
      hdr_seen  = 3'd0;
      fld_type  = 8'd0;
      fld_len   = 32'd0;
      fld_left  = 32'd0;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: expected no word, actual tdata=%h tuser=%h tlast=%b",
                   $time, m_tdata, m_tuser, m_tlast);
          fails++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", 32'(want.kind), 32'(m_tuser[1:0]));
          check_field("field_type", 32'(want.field_type), 32'(m_tdata[7:0]));
          check_field("field_length", want.field_length, m_tdata[39:8]);
          check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[47:40]));
          check_field("first_of_field", 32'(want.first_of_field), 32'(m_tuser[2]));
          check_field("last_of_field", 32'(want.last_of_field), 32'(m_tuser[3]));
          check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
      if (cfg_we) mode_pfx = cfg_data;
    end
    outstanding <= expected_words.size();
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  int fail_count;
  int pending;
  int word_count;
  int src_idle_pct;
  int snk_idle_pct;
  int sent;

  logic [7:0] body[$];
  logic [7:0] pkt[$];

  tlv_field_stream_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  tlv_stream_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fails       (fail_count),
    .outstanding (pending),
    .words_seen  (word_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_packet(input bit close);
    foreach (pkt[i]) send_byte(pkt[i], close && (i == pkt.size() - 1));
  endtask

  // hold off until every expected word is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic add_fields();
    int          nf;
    int          r;
    int          n;
    logic [31:0] len;
    nf = $urandom_range(1, 3);
    for (int f = 0; f < nf; f++) begin
      r = $urandom_range(99);
      if (r < 12) len = 32'd0;
      else if (r < 88) len = $urandom_range(1, 6);
      else len = $urandom;
      body = {body, 8'($urandom_range(255))};
      for (int k = 3; k >= 0; k--) body = {body, len[8*k +: 8]};
      n = (len > 32'd8) ? $urandom_range(0, 3) : int'(len);
      repeat (n) body = {body, 8'($urandom_range(255))};
      if (len > 32'd8) break;  // huge field always gets cut at packet end
    end
  endtask

  task automatic build_packet(input bit pfx);
    int          r;
    int          cut;
    logic [31:0] plen;
    body.delete();
    pkt.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) pkt = {pkt, 8'($urandom_range(255))};
      return;
    end
    add_fields();
    if (!pfx) begin
      pkt = body;
    end else begin
      plen = 32'(body.size());
      if (r < 18) plen = plen + $urandom_range(1, 3);
      else if (r < 26) plen = $urandom_range(0, plen);
      else if (r < 30) plen = $urandom;
      for (int k = 3; k >= 0; k--) pkt = {pkt, plen[8*k +: 8]};
      pkt = {pkt, body};
      if (r >= 30 && $urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) pkt = {pkt, 8'($urandom_range(255))};
    end
    if (r >= 30 && r < 40) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  task automatic run_segment(input bit pfx, input int src, input int snk, input int nbytes);
    int target;
    drain();
    set_mode(pfx);
    src_idle_pct = src;
    snk_idle_pct = snk;
    target = sent + nbytes;
    while (sent < target) begin
      build_packet(pfx);
      send_packet(1'b1);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = 8'd0;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    src_idle_pct = 28;
    snk_idle_pct = 51;
    sent         = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // raw fields: empty field, then a max-length field cut right after its header
    set_mode(1'b0);
    pkt = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet(1'b1);
    // packet ends inside a header: silently dropped
    pkt = '{8'h3C, 8'h00};
    send_packet(1'b1);

    drain();
    set_mode(1'b1);
    // prefix itself cut short
    pkt = '{8'hFF, 8'hFF};
    send_packet(1'b1);
    // zero body length, trailing byte ignored
    pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h5A};
    send_packet(1'b1);
    // body short mid-payload: short-frame discard instead of truncation
    pkt = '{8'h00, 8'h00, 8'h00, 8'h0A, 8'h01, 8'h00, 8'h00, 8'h00, 8'h05, 8'h77};
    send_packet(1'b1);
    // mode flips between bytes of one packet, counters carry over
    pkt = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h10};
    send_packet(1'b0);
    drain();
    set_mode(1'b0);
    pkt = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_packet(1'b1);

    run_segment(1'b0, 28, 51, 80);
    run_segment(1'b1, 28, 51, 80);
    run_segment(1'b1, 51, 28, 80);
    run_segment(1'b0, 51, 28, 80);
    run_segment(1'b1, 0, 0, 80);
    run_segment(1'b0, 0, 0, 80);
    drain();

    $display("summary: %0d bytes sent in raw and length-prefixed framing", sent);
    $display("summary: %0d result words compared under three stall profiles", word_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/tlvfsp_pkg.sv
sv/tlv_field_stream_parser.sv
dv/tlv_stream_checker.sv
dv/tb_top.sv
